// ===== sv/utcc_pkg.sv =====
// shared types, constants and calendar functions of the timestamp/calendar converter
package utcc_pkg;

  localparam logic [31:0] EPOCH_2000   = 32'd946684800;
  localparam logic [31:0] EPOCH_2100   = 32'd4102444800;
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  // epoch offset minus one day, the day count is carried plus one
  localparam logic [31:0] TS_BIAS      = 32'd946598400;

  // scaled reciprocals, quotient = (x * rcp) >> sh, exact over each dividend range
  // day: seconds >> 7 divided by 675
  localparam logic [25:0] RCP_DAY  = 26'd50903317;
  localparam int unsigned SH_DAY   = 35;
  localparam logic [17:0] RCP_HOUR = 18'd149131;
  localparam int unsigned SH_HOUR  = 29;
  localparam logic [12:0] RCP_MIN  = 13'd4370;
  localparam int unsigned SH_MIN   = 18;
  localparam logic [16:0] RCP_CYC  = 17'd91868;
  localparam int unsigned SH_CYC   = 27;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_DAY,
    ST_CAP_DAY,
    ST_DIV_HOUR,
    ST_CAP_HOUR,
    ST_DIV_MIN,
    ST_CAP_MIN,
    ST_DIV_CYC,
    ST_CAP_CYC,
    ST_YEAR,
    ST_MONTH,
    ST_CAL_A,
    ST_CAL_B,
    ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUOT,
    OP_RMDR,
    OP_DAYS,
    OP_HOUR,
    OP_MIN,
    OP_YEAR,
    OP_MONTH,
    OP_CAL_A,
    OP_CAL_B,
    OP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    DV_DAY,
    DV_HOUR,
    DV_MIN,
    DV_CYCLE
  } div_e;

  typedef struct packed {
    dp_op_e      op;
    div_e        div;
  } ctl_t;

  typedef struct packed {
    logic cmd;
    logic oor;
  } status_t;

  function automatic logic [16:0] divisor(input div_e d);
    logic [16:0] r;
    case (d)
      DV_DAY:   r = 17'd86400;
      DV_HOUR:  r = 17'd3600;
      DV_MIN:   r = 17'd60;
      DV_CYCLE: r = 17'd1461;
      default:  r = 17'd86400;
    endcase
    return r;
  endfunction

  // days before the first of month m, months past december count the whole year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0, 4'd1: base = 9'd0;
      4'd2:       base = 9'd31;
      4'd3:       base = 9'd59;
      4'd4:       base = 9'd90;
      4'd5:       base = 9'd120;
      4'd6:       base = 9'd151;
      4'd7:       base = 9'd181;
      4'd8:       base = 9'd212;
      4'd9:       base = 9'd243;
      4'd10:      base = 9'd273;
      4'd11:      base = 9'd304;
      4'd12:      base = 9'd334;
      default:    base = 9'd365;
    endcase
    return base + {8'd0, (leap && (m > 4'd2))};
  endfunction

  // 8 is 1 mod 7, so octal digits fold
  function automatic logic [2:0] mod7(input logic [15:0] x);
    logic [5:0] s;
    logic [3:0] f;
    s = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
      + {3'd0, x[14:12]} + {5'd0, x[15]};
    f = {1'b0, s[2:0]} + {1'b0, s[5:3]};
    if (f >= 4'd7) begin
      f = f - 4'd7;
    end
    return f[2:0];
  endfunction

endpackage

// ===== sv/utcc_ctrl.sv =====
// sequencer of the converter: handshakes, divide passes and datapath commands
module utcc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_stall_i,
  input  utcc_pkg::status_t  st_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output utcc_pkg::ctl_t     ctl_o
);

  utcc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= utcc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ctl_o     = '{op: utcc_pkg::OP_NONE, div: utcc_pkg::DV_DAY};
    case (state_q)
      utcc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = utcc_pkg::OP_LOAD;
          state_d  = utcc_pkg::ST_START;
        end
      end
      utcc_pkg::ST_START: begin
        if (st_i.cmd) begin
          state_d = utcc_pkg::ST_CAL_A;
        end else if (st_i.oor) begin
          state_d = utcc_pkg::ST_FIN;
        end else begin
          state_d = utcc_pkg::ST_DIV_DAY;
        end
      end
      utcc_pkg::ST_DIV_DAY: begin
        ctl_o.op  = utcc_pkg::OP_QUOT;
        ctl_o.div = utcc_pkg::DV_DAY;
        state_d   = utcc_pkg::ST_CAP_DAY;
      end
      utcc_pkg::ST_CAP_DAY: begin
        ctl_o.op  = utcc_pkg::OP_DAYS;
        ctl_o.div = utcc_pkg::DV_DAY;
        state_d   = utcc_pkg::ST_DIV_HOUR;
      end
      utcc_pkg::ST_DIV_HOUR: begin
        ctl_o.op  = utcc_pkg::OP_QUOT;
        ctl_o.div = utcc_pkg::DV_HOUR;
        state_d   = utcc_pkg::ST_CAP_HOUR;
      end
      utcc_pkg::ST_CAP_HOUR: begin
        ctl_o.op  = utcc_pkg::OP_HOUR;
        ctl_o.div = utcc_pkg::DV_HOUR;
        state_d   = utcc_pkg::ST_DIV_MIN;
      end
      utcc_pkg::ST_DIV_MIN: begin
        ctl_o.op  = utcc_pkg::OP_QUOT;
        ctl_o.div = utcc_pkg::DV_MIN;
        state_d   = utcc_pkg::ST_CAP_MIN;
      end
      utcc_pkg::ST_CAP_MIN: begin
        ctl_o.op  = utcc_pkg::OP_MIN;
        ctl_o.div = utcc_pkg::DV_MIN;
        state_d   = utcc_pkg::ST_DIV_CYC;
      end
      utcc_pkg::ST_DIV_CYC: begin
        ctl_o.op  = utcc_pkg::OP_QUOT;
        ctl_o.div = utcc_pkg::DV_CYCLE;
        state_d   = utcc_pkg::ST_CAP_CYC;
      end
      utcc_pkg::ST_CAP_CYC: begin
        ctl_o.op  = utcc_pkg::OP_RMDR;
        ctl_o.div = utcc_pkg::DV_CYCLE;
        state_d   = utcc_pkg::ST_YEAR;
      end
      utcc_pkg::ST_YEAR: begin
        ctl_o.op = utcc_pkg::OP_YEAR;
        state_d  = utcc_pkg::ST_MONTH;
      end
      utcc_pkg::ST_MONTH: begin
        ctl_o.op = utcc_pkg::OP_MONTH;
        state_d  = utcc_pkg::ST_FIN;
      end
      utcc_pkg::ST_CAL_A: begin
        ctl_o.op = utcc_pkg::OP_CAL_A;
        state_d  = utcc_pkg::ST_CAL_B;
      end
      utcc_pkg::ST_CAL_B: begin
        ctl_o.op = utcc_pkg::OP_CAL_B;
        state_d  = utcc_pkg::ST_FIN;
      end
      utcc_pkg::ST_FIN: begin
        // wait until the result register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.op = utcc_pkg::OP_OUT;
          state_d  = utcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = utcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.op == utcc_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != utcc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/utcc_dpath.sv =====
// datapath of the converter: request registers, constant dividers, calendar logic, result register
module utcc_dpath (
  input  logic               clk_i,
  input  utcc_pkg::ctl_t     ctl_i,
  output utcc_pkg::status_t  st_o,
  input  logic               command_i,
  input  logic [31:0]        unix_seconds_in_i,
  input  logic [6:0]         year_offset_in_i,
  input  logic [3:0]         month_in_i,
  input  logic [4:0]         day_in_i,
  input  logic [4:0]         hour_in_i,
  input  logic [5:0]         minute_in_i,
  input  logic [5:0]         second_in_i,
  output logic [31:0]        unix_seconds_out_o,
  output logic [6:0]         year_offset_out_o,
  output logic [3:0]         month_out_o,
  output logic [4:0]         day_out_o,
  output logic [4:0]         hour_out_o,
  output logic [5:0]         minute_out_o,
  output logic [5:0]         second_out_o,
  output logic [2:0]         weekday_o,
  output logic               out_of_range_o
);

  // request
  logic        cmd_q;
  logic [31:0] secs_q;
  logic [6:0]  yr_q;
  logic [3:0]  mo_q;
  logic [4:0]  dy_q;
  logic [4:0]  hr_q;
  logic [5:0]  mi_q;
  logic [5:0]  se_q;

  // divider and work registers
  logic [31:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [50:0] prod;
  logic [15:0] days_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [6:0]  year_q;
  logic [8:0]  doy_q;
  logic        leap_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [2:0]  wday_q;
  logic [15:0] dp_q;
  logic [31:0] pd_q;
  logic [16:0] hms_q;

  logic        oor;
  logic [10:0] cyc_rem;
  logic [1:0]  yy;
  logic [10:0] yy_start;
  logic [3:0]  mon;
  logic [8:0]  mon_start;
  logic [15:0] dp_d;

  // quotient by a constant from a reciprocal multiply, remainder in the following cycle
  always_comb begin
    case (ctl_i.div)
      utcc_pkg::DV_DAY: begin
        // 86400 is 675 times 128, the power of two comes off first
        prod  = 51'(rem_q[31:7]) * 51'(utcc_pkg::RCP_DAY);
        quo_d = 16'(prod >> utcc_pkg::SH_DAY);
      end
      utcc_pkg::DV_HOUR: begin
        prod  = 51'(rem_q[16:0]) * 51'(utcc_pkg::RCP_HOUR);
        quo_d = 16'(prod >> utcc_pkg::SH_HOUR);
      end
      utcc_pkg::DV_MIN: begin
        prod  = 51'(rem_q[11:0]) * 51'(utcc_pkg::RCP_MIN);
        quo_d = 16'(prod >> utcc_pkg::SH_MIN);
      end
      utcc_pkg::DV_CYCLE: begin
        prod  = 51'(rem_q[15:0]) * 51'(utcc_pkg::RCP_CYC);
        quo_d = 16'(prod >> utcc_pkg::SH_CYC);
      end
      default: begin
        prod  = '0;
        quo_d = '0;
      end
    endcase
    rem_d = rem_q - {16'd0, quo_q} * {15'd0, utcc_pkg::divisor(ctl_i.div)};
  end

  // year within the four-year cycle, the first one is the leap year
  always_comb begin
    cyc_rem = rem_q[10:0];
    if (cyc_rem < 11'd366) begin
      yy       = 2'd0;
      yy_start = 11'd0;
    end else if (cyc_rem < 11'd731) begin
      yy       = 2'd1;
      yy_start = 11'd366;
    end else if (cyc_rem < 11'd1096) begin
      yy       = 2'd2;
      yy_start = 11'd731;
    end else begin
      yy       = 2'd3;
      yy_start = 11'd1096;
    end
  end

  // month by parallel compares against the month boundaries
  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy_q >= utcc_pkg::month_start(4'(k), leap_q)) begin
        mon = mon + 4'd1;
      end
    end
    mon_start = utcc_pkg::month_start(mon, leap_q);
  end

  // day count plus one for a calendar request
  assign dp_d = {11'd0, dy_q}
              + {7'd0, utcc_pkg::month_start(mo_q, (yr_q[1:0] == 2'b00))}
              + 16'({9'd0, yr_q} * 16'd365)
              + {10'd0, 6'(({1'b0, yr_q} + 8'd3) >> 2)};

  assign oor = (secs_q < utcc_pkg::EPOCH_2000) || (secs_q >= utcc_pkg::EPOCH_2100);

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      utcc_pkg::OP_LOAD: begin
        cmd_q  <= command_i;
        secs_q <= unix_seconds_in_i;
        yr_q   <= year_offset_in_i;
        mo_q   <= month_in_i;
        dy_q   <= day_in_i;
        hr_q   <= hour_in_i;
        mi_q   <= minute_in_i;
        se_q   <= second_in_i;
        rem_q  <= unix_seconds_in_i - utcc_pkg::EPOCH_2000;
        quo_q  <= '0;
      end
      utcc_pkg::OP_QUOT: begin
        quo_q <= quo_d;
      end
      utcc_pkg::OP_RMDR: begin
        rem_q <= rem_d;
      end
      utcc_pkg::OP_DAYS: begin
        days_q <= quo_q;
        wday_q <= utcc_pkg::mod7(quo_q + 16'd6);
        rem_q  <= rem_d;
      end
      utcc_pkg::OP_HOUR: begin
        hour_q <= quo_q[4:0];
        rem_q  <= rem_d;
      end
      utcc_pkg::OP_MIN: begin
        minute_q <= quo_q[5:0];
        second_q <= rem_d[5:0];
        rem_q    <= {16'd0, days_q};
      end
      utcc_pkg::OP_YEAR: begin
        year_q <= {quo_q[4:0], 2'b00} + {5'd0, yy};
        doy_q  <= 9'(cyc_rem - yy_start);
        leap_q <= (yy == 2'd0);
      end
      utcc_pkg::OP_MONTH: begin
        month_q <= mon;
        day_q   <= 5'(doy_q - mon_start + 9'd1);
      end
      utcc_pkg::OP_CAL_A: begin
        dp_q <= dp_d;
      end
      utcc_pkg::OP_CAL_B: begin
        pd_q   <= 32'({16'd0, dp_q} * utcc_pkg::SECS_PER_DAY);
        hms_q  <= 17'({12'd0, hr_q} * 17'd3600) + 17'({11'd0, mi_q} * 17'd60)
                + {11'd0, se_q};
        wday_q <= utcc_pkg::mod7(dp_q + 16'd5);
      end
      utcc_pkg::OP_OUT: begin
        if (cmd_q) begin
          unix_seconds_out_o <= pd_q + {15'd0, hms_q} + utcc_pkg::TS_BIAS;
          year_offset_out_o  <= yr_q;
          month_out_o        <= mo_q;
          day_out_o          <= dy_q;
          hour_out_o         <= hr_q;
          minute_out_o       <= mi_q;
          second_out_o       <= se_q;
          weekday_o          <= wday_q;
          out_of_range_o     <= 1'b0;
        end else if (oor) begin
          unix_seconds_out_o <= secs_q;
          year_offset_out_o  <= '0;
          month_out_o        <= '0;
          day_out_o          <= '0;
          hour_out_o         <= '0;
          minute_out_o       <= '0;
          second_out_o       <= '0;
          weekday_o          <= '0;
          out_of_range_o     <= 1'b1;
        end else begin
          unix_seconds_out_o <= secs_q;
          year_offset_out_o  <= year_q;
          month_out_o        <= month_q;
          day_out_o          <= day_q;
          hour_out_o         <= hour_q;
          minute_out_o       <= minute_q;
          second_out_o       <= second_q;
          weekday_o          <= wday_q;
          out_of_range_o     <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign st_o.cmd = cmd_q;
  assign st_o.oor = oor;

endmodule

// ===== sv/unix_time_calendar_converter_unit.sv =====
// timestamp to calendar: day, hour, minute and four-year cycle divides, then the year and month
// steps, then the result register; out of range goes from the range check straight to the result
// calendar to timestamp: the CAL_A and CAL_B steps, then the result register. the next transfer
// in can be taken once the result is registered; each divide is a reciprocal multiply and a remainder step
// a held result does not block the next transfer in; the block waits only when a new
// result is ready and the old one is still stalled. async reset clears control only
module unix_time_calendar_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] unix_seconds_in_i,
  input  logic [6:0]  year_offset_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [4:0]  hour_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [5:0]  second_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] unix_seconds_out_o,
  output logic [6:0]  year_offset_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic [2:0]  weekday_o,
  output logic        out_of_range_o
);

  utcc_pkg::ctl_t    ctl;
  utcc_pkg::status_t st;

  utcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  utcc_dpath u_dpath (
    .clk_i              (clk_i),
    .ctl_i              (ctl),
    .st_o               (st),
    .command_i          (command_i),
    .unix_seconds_in_i  (unix_seconds_in_i),
    .year_offset_in_i   (year_offset_in_i),
    .month_in_i         (month_in_i),
    .day_in_i           (day_in_i),
    .hour_in_i          (hour_in_i),
    .minute_in_i        (minute_in_i),
    .second_in_i        (second_in_i),
    .unix_seconds_out_o (unix_seconds_out_o),
    .year_offset_out_o  (year_offset_out_o),
    .month_out_o        (month_out_o),
    .day_out_o          (day_out_o),
    .hour_out_o         (hour_out_o),
    .minute_out_o       (minute_out_o),
    .second_out_o       (second_out_o),
    .weekday_o          (weekday_o),
    .out_of_range_o     (out_of_range_o)
  );

  // a transfer in always starts work, so the input side is busy next cycle
  a_busy_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer in");

  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |->
      (month_out_o == '0 && day_out_o == '0 && weekday_o == '0 && year_offset_out_o == '0))
    else $error("out of range result with nonzero date fields");

  a_weekday_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (weekday_o != 3'd7))
    else $error("weekday out of range");

endmodule
